/* sv/neutrino_pz_mass_constraint_solver_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the neutrino pz solver
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef NEUTRINO_PZ_MASS_CONSTRAINT_SOLVER_MACROS_SVH
`define NEUTRINO_PZ_MASS_CONSTRAINT_SOLVER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define NPZ_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define NPZ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* sv/npz_pkg.sv */
// ----------------------------------------------------------------------------
// npz_pkg
// Widths, payload types and cell records for the W-mass pz solver.
// ----------------------------------------------------------------------------
package npz_pkg;

	// field widths
	localparam int MOM_W  = 24;
	localparam int E_W    = 23;
	localparam int W_W    = 20;
	localparam int OUT_W  = 32;
	localparam logic [W_W-1:0] W_RESET = 20'd5144;

	// front end arithmetic
	localparam int PROD_W = 2 * MOM_W;
	localparam int EE_W   = 2 * E_W;
	localparam int WW_W   = 2 * W_W;
	localparam int A2_W   = 50;
	localparam int A2M_W  = A2_W - 1;
	localparam int A2L_W  = 25;
	localparam int A2H_W  = A2M_W - A2L_W;
	localparam int D_W    = 47;
	localparam int DM_W   = 47;
	localparam int DL_W   = 24;
	localparam int DH_W   = DM_W - DL_W;
	localparam int MET_W  = 48;
	localparam int ML_W   = 24;
	localparam int MH_W   = MET_W - ML_W;
	localparam int T1_W   = 98;
	localparam int T2_W   = 96;
	localparam int B_W    = 72;

	// square root chain
	localparam int Q_W    = 100;
	localparam int S_W    = Q_W / 2;
	localparam int SL_W   = 25;
	localparam int SH_W   = S_W - SL_W;
	localparam int REM_W  = S_W + 2;
	localparam int SQRT_CELLS = S_W;

	// numerators and divide chain
	localparam int RP_W   = E_W + SL_W;
	localparam int R_W    = 73;
	localparam int N_W    = 75;
	localparam int NM_W   = N_W - 1;
	localparam int NR_W   = 75;
	localparam int DEN_W  = DM_W + 1;
	localparam int QUO_W  = 33;
	localparam int DIV_CELLS = QUO_W;
	localparam int NLANE  = 2;

	localparam logic [QUO_W-1:0] POS_LIM = 33'h0_7FFF_FFFF;
	localparam logic [QUO_W-1:0] NEG_LIM = 33'h0_8000_0000;
	localparam logic [OUT_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
	localparam logic [OUT_W-1:0] OUT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [MOM_W-1:0] vis_px;
		logic signed [MOM_W-1:0] vis_py;
		logic signed [MOM_W-1:0] vis_pz;
		logic [E_W-1:0]          vis_energy;
		logic signed [MOM_W-1:0] miss_px;
		logic signed [MOM_W-1:0] miss_py;
	} npz_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] pz_small;
		logic signed [OUT_W-1:0] pz_large;
		logic                    no_real_root;
		logic                    zero_denominator;
		logic                    saturated;
	} npz_out_t;

	// per-item values that ride along the root chain
	typedef struct packed {
		logic [E_W-1:0]  e;
		logic [B_W-1:0]  bmag;
		logic            bneg;
		logic [DM_W-1:0] dm;
		logic            dzero;
		logic            noroot;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [S_W-1:0]   root;
		logic [Q_W-1:0]   qsh;
		side_t            side;
	} sqrt_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] nlow;
		logic [QUO_W-1:0] quot;
		logic             neg;
		logic             ovf;
	} lane_t;

	// lane 0 carries the smaller-magnitude root, lane 1 the larger
	typedef struct packed {
		logic [DEN_W-1:0]       den;
		logic                   dzero;
		logic                   noroot;
		lane_t [NLANE-1:0]      lane;
	} div_t;

endpackage

/* sv/npz_prep.sv */
// ----------------------------------------------------------------------------
// npz_prep
// Six-stage front end: products, A2, d, met^2, split wide products, Q.
// ----------------------------------------------------------------------------
module npz_prep (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        up_valid,
	input  npz_pkg::npz_in_t            up,
	input  logic [npz_pkg::W_W-1:0]     w_mass,
	output logic                        dn_valid,
	output npz_pkg::sqrt_t              dn
);
	import npz_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// stage 1 registers
	logic [EE_W-1:0]          ee_s1;
	logic [WW_W-1:0]          ww_s1;
	logic signed [PROD_W-1:0] pxx_s1, pyy_s1, pzz_s1, mxx_s1, myy_s1, pxm_s1, pym_s1;
	logic [E_W-1:0]           e_s1;
	logic signed [MOM_W-1:0]  pz_s1;

	// stage 2 registers
	logic signed [A2_W-1:0]   a2_s2;
	logic signed [D_W-1:0]    d_s2;
	logic [MET_W-1:0]         met_s2;
	logic [E_W-1:0]           e_s2;
	logic signed [MOM_W-1:0]  pz_s2;

	// stage 3 registers
	logic [A2M_W-1:0]         a2m_s3;
	logic [DM_W-1:0]          dm_s3;
	logic [MOM_W-1:0]         pzm_s3;
	logic                     bsign_s3, dneg_s3, dzero_s3;
	logic [MET_W-1:0]         met_s3;
	logic [E_W-1:0]           e_s3;

	// stage 4 registers
	logic [2*A2H_W-1:0]       hh_s4;
	logic [A2H_W+A2L_W-1:0]   hl_s4;
	logic [2*A2L_W-1:0]       ll_s4;
	logic [DL_W+ML_W-1:0]     pll_s4;
	logic [DL_W+MH_W-1:0]     plh_s4;
	logic [DH_W+ML_W-1:0]     phl_s4;
	logic [DH_W+MH_W-1:0]     phh_s4;
	logic [A2L_W+MOM_W-1:0]   bl_s4;
	logic [A2H_W+MOM_W-1:0]   bh_s4;
	logic                     bsign_s4, dneg_s4, dzero_s4;
	logic [DM_W-1:0]          dm_s4;
	logic [E_W-1:0]           e_s4;

	// stage 5 registers
	logic [T1_W-1:0]          t1_s5;
	logic [T2_W-1:0]          t2_s5;
	logic [B_W-1:0]           bmag_s5;
	logic                     bsign_s5, dneg_s5, dzero_s5;
	logic [DM_W-1:0]          dm_s5;
	logic [E_W-1:0]           e_s5;

	logic signed [A2_W-1:0]   a2_sum;
	logic signed [D_W-1:0]    d_sum;
	logic [Q_W-1:0]           q_add, q_sub, q_val;
	logic                     q_pos, no_root;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= up_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// form all narrow products
	always_ff @(posedge clk) begin
		if (en) begin
			ee_s1  <= up.vis_energy * up.vis_energy;
			ww_s1  <= w_mass * w_mass;
			pxx_s1 <= up.vis_px * up.vis_px;
			pyy_s1 <= up.vis_py * up.vis_py;
			pzz_s1 <= up.vis_pz * up.vis_pz;
			mxx_s1 <= up.miss_px * up.miss_px;
			myy_s1 <= up.miss_py * up.miss_py;
			pxm_s1 <= up.vis_px * up.miss_px;
			pym_s1 <= up.vis_py * up.miss_py;
			e_s1   <= up.vis_energy;
			pz_s1  <= up.vis_pz;
		end
	end

	// A2 = W^2 - m^2 + 2(px*mx + py*my), d = E^2 - pz^2
	assign a2_sum = A2_W'(ww_s1) - A2_W'(ee_s1) + A2_W'(pxx_s1) + A2_W'(pyy_s1)
		+ A2_W'(pzz_s1) + (A2_W'(pxm_s1) <<< 1) + (A2_W'(pym_s1) <<< 1);
	assign d_sum = D_W'(ee_s1) - D_W'(pzz_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			a2_s2  <= a2_sum;
			d_s2   <= d_sum;
			met_s2 <= MET_W'(mxx_s1) + MET_W'(myy_s1);
			e_s2   <= e_s1;
			pz_s2  <= pz_s1;
		end
	end

	// take magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			a2m_s3   <= a2_s2[A2_W-1] ? A2M_W'(-a2_s2) : A2M_W'(a2_s2);
			dm_s3    <= d_s2[D_W-1] ? DM_W'(-d_s2) : DM_W'(d_s2);
			pzm_s3   <= pz_s2[MOM_W-1] ? MOM_W'(-pz_s2) : MOM_W'(pz_s2);
			bsign_s3 <= a2_s2[A2_W-1] ^ pz_s2[MOM_W-1] ^ d_s2[D_W-1];
			dneg_s3  <= d_s2[D_W-1];
			dzero_s3 <= (d_s2 == '0);
			met_s3   <= met_s2;
			e_s3     <= e_s2;
		end
	end

	// split A2^2, |d|*met^2 and |A2|*|pz| into partial products
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s4    <= a2m_s3[A2M_W-1:A2L_W] * a2m_s3[A2M_W-1:A2L_W];
			hl_s4    <= a2m_s3[A2M_W-1:A2L_W] * a2m_s3[A2L_W-1:0];
			ll_s4    <= a2m_s3[A2L_W-1:0] * a2m_s3[A2L_W-1:0];
			pll_s4   <= dm_s3[DL_W-1:0] * met_s3[ML_W-1:0];
			plh_s4   <= dm_s3[DL_W-1:0] * met_s3[MET_W-1:ML_W];
			phl_s4   <= dm_s3[DM_W-1:DL_W] * met_s3[ML_W-1:0];
			phh_s4   <= dm_s3[DM_W-1:DL_W] * met_s3[MET_W-1:ML_W];
			bl_s4    <= a2m_s3[A2L_W-1:0] * pzm_s3;
			bh_s4    <= a2m_s3[A2M_W-1:A2L_W] * pzm_s3;
			bsign_s4 <= bsign_s3;
			dneg_s4  <= dneg_s3;
			dzero_s4 <= dzero_s3;
			dm_s4    <= dm_s3;
			e_s4     <= e_s3;
		end
	end

	// sum partial products: t1 = A2^2, t2 = 4|d|met^2
	always_ff @(posedge clk) begin
		if (en) begin
			t1_s5    <= (T1_W'(hh_s4) << (2 * A2L_W)) + (T1_W'(hl_s4) << (A2L_W + 1))
				+ T1_W'(ll_s4);
			t2_s5    <= (T2_W'(phh_s4) << (DL_W + ML_W + 2))
				+ (T2_W'(plh_s4) << (ML_W + 2)) + (T2_W'(phl_s4) << (DL_W + 2))
				+ (T2_W'(pll_s4) << 2);
			bmag_s5  <= (B_W'(bh_s4) << A2L_W) + B_W'(bl_s4);
			bsign_s5 <= bsign_s4;
			dneg_s5  <= dneg_s4;
			dzero_s5 <= dzero_s4;
			dm_s5    <= dm_s4;
			e_s5     <= e_s4;
		end
	end

	// Q = A2^2 - 4 d met^2; clamp when not positive or E is zero
	assign q_add   = Q_W'(t1_s5) + Q_W'(t2_s5);
	assign q_sub   = Q_W'(t1_s5) - Q_W'(t2_s5);
	assign q_pos   = dneg_s5 ? ((t1_s5 != '0) || (t2_s5 != '0)) : (Q_W'(t1_s5) > Q_W'(t2_s5));
	assign no_root = !(q_pos && (e_s5 != '0));
	assign q_val   = no_root ? '0 : (dneg_s5 ? q_add : q_sub);

	always_ff @(posedge clk) begin
		if (en) begin
			dn.rem         <= '0;
			dn.root        <= '0;
			dn.qsh         <= q_val;
			dn.side.e      <= e_s5;
			dn.side.bmag   <= bmag_s5;
			dn.side.bneg   <= bsign_s5 && (bmag_s5 != '0);
			dn.side.dm     <= dm_s5;
			dn.side.dzero  <= dzero_s5;
			dn.side.noroot <= no_root;
		end
	end

	assign dn_valid = v_s6;

endmodule

/* sv/npz_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// npz_sqrt_cell
// One digit of the integer square root: takes two radicand bits, yields
// one root bit, hands the partial root and remainder to the next cell.
// ----------------------------------------------------------------------------
module npz_sqrt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            up_valid,
	input  npz_pkg::sqrt_t  up,
	output logic            dn_valid,
	output npz_pkg::sqrt_t  dn
);
	import npz_pkg::*;

	logic             v_q;
	sqrt_t            st_q;
	logic [REM_W-1:0] r2, trial;
	logic             ge;

	// trial subtract of 4*root+1 from the shifted remainder
	assign r2    = {up.rem[REM_W-3:0], up.qsh[Q_W-1 -: 2]};
	assign trial = {up.root, 2'b01};
	assign ge    = (r2 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= up_valid;
		end
	end

	// advance remainder, root and radicand
	always_ff @(posedge clk) begin
		if (en) begin
			st_q.rem  <= ge ? (r2 - trial) : r2;
			st_q.root <= {up.root[S_W-2:0], ge};
			st_q.qsh  <= {up.qsh[Q_W-3:0], 2'b00};
			st_q.side <= up.side;
		end
	end

	assign dn_valid = v_q;
	assign dn       = st_q;

endmodule

/* sv/npz_num.sv */
// ----------------------------------------------------------------------------
// npz_num
// Seven-stage middle section: E*s, the two numerators, magnitude order,
// rounding offset and overflow check that seed the divide chain.
// ----------------------------------------------------------------------------
module npz_num (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            up_valid,
	input  npz_pkg::sqrt_t  up,
	output logic            dn_valid,
	output npz_pkg::div_t   dn
);
	import npz_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [RP_W-1:0]        rlo_s1, rhi_s1;
	side_t                  side_s1;
	logic [R_W-1:0]         rmag_s2;
	side_t                  side_s2;
	logic signed [N_W-1:0]  nm_s3, np_s3;
	logic [DM_W-1:0]        dm_s3, dm_s4, dm_s5, dm_s6;
	logic                   dzero_s3, dzero_s4, dzero_s5, dzero_s6;
	logic                   noroot_s3, noroot_s4, noroot_s5, noroot_s6;
	logic [NM_W-1:0]        magm_s4, magp_s4;
	logic                   negm_s4, negp_s4;
	logic [NM_W-1:0]        mag_s5 [NLANE];
	logic                   neg_s5 [NLANE], neg_s6 [NLANE];
	logic [NR_W-1:0]        n_s6 [NLANE];
	logic signed [N_W-1:0]  b_sgn;
	logic                   m_lt, m_gt;
	div_t                   nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= up_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// partial products of E * s
	always_ff @(posedge clk) begin
		if (en) begin
			rlo_s1  <= up.side.e * up.root[SL_W-1:0];
			rhi_s1  <= up.side.e * up.root[S_W-1:SL_W];
			side_s1 <= up.side;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rmag_s2 <= (R_W'(rhi_s1) << SL_W) + R_W'(rlo_s1);
			side_s2 <= side_s1;
		end
	end

	// Nm = b - E*s, Np = b + E*s with the sign of d folded into b
	assign b_sgn = side_s2.bneg ? -N_W'(side_s2.bmag) : N_W'(side_s2.bmag);

	always_ff @(posedge clk) begin
		if (en) begin
			nm_s3     <= b_sgn - N_W'(rmag_s2);
			np_s3     <= b_sgn + N_W'(rmag_s2);
			dm_s3     <= side_s2.dm;
			dzero_s3  <= side_s2.dzero;
			noroot_s3 <= side_s2.noroot;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			magm_s4   <= nm_s3[N_W-1] ? NM_W'(-nm_s3) : NM_W'(nm_s3);
			magp_s4   <= np_s3[N_W-1] ? NM_W'(-np_s3) : NM_W'(np_s3);
			negm_s4   <= nm_s3[N_W-1];
			negp_s4   <= np_s3[N_W-1];
			dm_s4     <= dm_s3;
			dzero_s4  <= dzero_s3;
			noroot_s4 <= noroot_s3;
		end
	end

	// order by exact magnitude; a tie sends Np to both lanes
	assign m_lt = (magm_s4 < magp_s4);
	assign m_gt = (magm_s4 > magp_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5[0] <= m_lt ? magm_s4 : magp_s4;
			neg_s5[0] <= m_lt ? negm_s4 : negp_s4;
			mag_s5[1] <= m_gt ? magm_s4 : magp_s4;
			neg_s5[1] <= m_gt ? negm_s4 : negp_s4;
			dm_s5     <= dm_s4;
			dzero_s5  <= dzero_s4;
			noroot_s5 <= noroot_s4;
		end
	end

	// add half the denominator for round half away from zero
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NLANE; i++) begin
				n_s6[i]   <= NR_W'(mag_s5[i]) + NR_W'(dm_s5);
				neg_s6[i] <= neg_s5[i];
			end
			dm_s6     <= dm_s5;
			dzero_s6  <= dzero_s5;
			noroot_s6 <= noroot_s5;
		end
	end

	// seed the divide: flag quotients past the lane width
	always_comb begin
		nxt.den    = {dm_s6, 1'b0};
		nxt.dzero  = dzero_s6;
		nxt.noroot = noroot_s6;
		for (int i = 0; i < NLANE; i++) begin
			nxt.lane[i].rem  = DEN_W'(n_s6[i][NR_W-1:QUO_W]);
			nxt.lane[i].nlow = n_s6[i][QUO_W-1:0];
			nxt.lane[i].quot = '0;
			nxt.lane[i].neg  = neg_s6[i];
			nxt.lane[i].ovf  = (DEN_W'(n_s6[i][NR_W-1:QUO_W]) >= {dm_s6, 1'b0});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn <= nxt;
		end
	end

	assign dn_valid = v_s7;

endmodule

/* sv/npz_div_cell.sv */
// ----------------------------------------------------------------------------
// npz_div_cell
// One quotient bit of the restoring divide, for both root lanes.
// ----------------------------------------------------------------------------
module npz_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            up_valid,
	input  npz_pkg::div_t   up,
	output logic            dn_valid,
	output npz_pkg::div_t   dn
);
	import npz_pkg::*;

	logic           v_q;
	div_t           st_q;
	div_t           nxt;
	logic [DEN_W:0] r2 [NLANE];
	logic           ge [NLANE];

	// shift in one numerator bit, subtract the denominator when it fits
	always_comb begin
		nxt = up;
		for (int i = 0; i < NLANE; i++) begin
			r2[i] = {up.lane[i].rem, up.lane[i].nlow[QUO_W-1]};
			ge[i] = (r2[i] >= {1'b0, up.den});
			nxt.lane[i].rem  = ge[i] ? DEN_W'(r2[i] - {1'b0, up.den}) : DEN_W'(r2[i]);
			nxt.lane[i].nlow = {up.lane[i].nlow[QUO_W-2:0], 1'b0};
			nxt.lane[i].quot = {up.lane[i].quot[QUO_W-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

	assign dn_valid = v_q;
	assign dn       = st_q;

endmodule

/* sv/neutrino_pz_mass_constraint_solver.sv */
// 97 register stages lie between a request on in_data and its result on out_data.
// Throughput: one request per cycle while the skid register is empty, held by the 50-cell square-root
// chain and the 33-cell divide chain, each cell retiring one digit per clock while enabled.
// A full skid register stalls the input and freezes the whole pipeline.
// Reset clears every valid bit and both output registers' valids; w_mass returns to 5144.
// ----------------------------------------------------------------------------
// neutrino_pz_mass_constraint_solver
// Solves the W-mass constraint quadratic for the missing longitudinal
// momentum: front end, root chain, numerators, divide chain, output skid.
// ----------------------------------------------------------------------------
module neutrino_pz_mass_constraint_solver (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [npz_pkg::W_W-1:0]  cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  npz_pkg::npz_in_t         in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output npz_pkg::npz_out_t        out_data
);
	import npz_pkg::*;

	logic [W_W-1:0] w_mass_q;
	logic           en;

	sqrt_t          sq_chain [SQRT_CELLS+1];
	logic           sq_v     [SQRT_CELLS+1];
	div_t           dv_chain [DIV_CELLS+1];
	logic           dv_v     [DIV_CELLS+1];

	npz_out_t       fmt;
	npz_out_t       out_q, skid_q;
	logic           out_v_q, skid_v_q;
	logic           take, from_pipe;
	logic [OUT_W-1:0] val [NLANE];
	logic           sat [NLANE];
	div_t           last;

	// hold the constraint mass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_mass_q <= W_RESET;
		end else if (cfg_we) begin
			w_mass_q <= cfg_data;
		end
	end

	// pipeline moves whenever the skid register is empty
	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;

	npz_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (in_valid),
		.up       (in_data),
		.w_mass   (w_mass_q),
		.dn_valid (sq_v[0]),
		.dn       (sq_chain[0])
	);

	// square-root cells
	for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
		npz_sqrt_cell u_sqrt (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (sq_v[i]),
			.up       (sq_chain[i]),
			.dn_valid (sq_v[i+1]),
			.dn       (sq_chain[i+1])
		);
	end

	npz_num u_num (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (sq_v[SQRT_CELLS]),
		.up       (sq_chain[SQRT_CELLS]),
		.dn_valid (dv_v[0]),
		.dn       (dv_chain[0])
	);

	// divide cells
	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
		npz_div_cell u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (dv_v[i]),
			.up       (dv_chain[i]),
			.dn_valid (dv_v[i+1]),
			.dn       (dv_chain[i+1])
		);
	end

	assign last = dv_chain[DIV_CELLS];

	// saturate, apply sign, force zeros on a zero denominator
	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			if (last.lane[i].neg) begin
				sat[i] = last.lane[i].ovf || (last.lane[i].quot > NEG_LIM);
				val[i] = sat[i] ? OUT_MIN : (OUT_W'(0) - last.lane[i].quot[OUT_W-1:0]);
			end else begin
				sat[i] = last.lane[i].ovf || (last.lane[i].quot > POS_LIM);
				val[i] = sat[i] ? OUT_MAX : last.lane[i].quot[OUT_W-1:0];
			end
		end
		fmt.pz_small         = last.dzero ? '0 : val[0];
		fmt.pz_large         = last.dzero ? '0 : val[1];
		fmt.no_real_root     = !last.dzero && last.noroot;
		fmt.zero_denominator = last.dzero;
		fmt.saturated        = !last.dzero && (sat[0] || sat[1]);
	end

	// output register with skid stage
	assign take      = out_v_q && !out_stall;
	assign from_pipe = en && dv_v[DIV_CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (from_pipe) begin
			if (out_v_q && !take) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (from_pipe) begin
			if (out_v_q && !take) begin
				skid_q <= fmt;
			end else begin
				out_q <= fmt;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

/* sv/npz_checker.sv */
// ----------------------------------------------------------------------------
// npz_checker
// Port-level checks on the solver outputs, bound to the top level.
// ----------------------------------------------------------------------------
`include "neutrino_pz_mass_constraint_solver_macros.svh"

module npz_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input npz_pkg::npz_out_t  out_data
);
	import npz_pkg::*;

	logic [OUT_W:0] mag_small, mag_large;

	// magnitudes of both roots, one bit wider to hold 2^31
	assign mag_small = out_data.pz_small[OUT_W-1]
		? ((OUT_W+1)'(0) - {out_data.pz_small[OUT_W-1], out_data.pz_small})
		: {1'b0, out_data.pz_small};
	assign mag_large = out_data.pz_large[OUT_W-1]
		? ((OUT_W+1)'(0) - {out_data.pz_large[OUT_W-1], out_data.pz_large})
		: {1'b0, out_data.pz_large};

	`NPZ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

	`NPZ_ASSERT_SAME(a_stall_full, in_stall, out_valid, "input stalled with empty output")

	`NPZ_ASSERT_SAME(a_zero_den, out_valid && out_data.zero_denominator, (out_data.pz_small == '0) && (out_data.pz_large == '0) && !out_data.no_real_root && !out_data.saturated, "zero denominator result not cleared")

	`NPZ_ASSERT_SAME(a_no_root_tie, out_valid && out_data.no_real_root, out_data.pz_small == out_data.pz_large, "clamped root gave two values")

	`NPZ_ASSERT_SAME(a_order, out_valid && !out_data.saturated, mag_small <= mag_large, "roots out of magnitude order")

endmodule

bind neutrino_pz_mass_constraint_solver npz_checker u_npz_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
